// ===== rtl/rbf_pkg.sv =====
// Package for the resonant biquad filter: shared types, widths, codes and tables.
// No dependencies; every other file of the block but the request queue imports it.
package rbf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;
    localparam int TAN_DEPTH   = 1024;
    localparam int TAN_LOG     = 10;
    localparam int FSCL_BITS   = 17 + TAN_LOG + 1;
    localparam int DVD_BITS    = 62;
    localparam int DVS_BITS    = 32;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_Q    = 2'd1;
    localparam logic [1:0] CFG_FS   = 2'd2;

    // filter modes
    localparam logic [1:0] MODE_LP = 2'd0;
    localparam logic [1:0] MODE_HP = 2'd1;
    localparam logic [1:0] MODE_BP = 2'd2;

    localparam logic [17:0] FS_MIN    = 18'd1000;
    localparam logic [17:0] FS_MAX    = 18'd192000;
    localparam logic [17:0] FS_RESET  = 18'd48000;
    localparam logic [12:0] Q_MIN     = 13'd256;
    localparam logic signed [33:0] Q_ONE  = 34'sd1073741824;
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    typedef logic signed [33:0] t_q30;

    typedef struct packed {
        logic                          clear;
        logic signed [SAMPLE_BITS-1:0] x;
        logic [FSCL_BITS-1:0]          fscl;
    } t_job;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] qq;
        logic [17:0] fs;
    } t_cfg;

    // Taylor term divisors (sine steps first, then cosine steps):
    // 110 72 42 20 6, then 132 90 56 30 12 2.
    // Shift for each step: 32 plus the bit length of its divisor, but 33 for the divisor 2.
    function automatic logic [5:0] horner_shift(input logic [3:0] idx);
        logic [5:0] s;
        unique case (idx)
            4'd0, 4'd1, 4'd6: s = 6'd39;
            4'd2, 4'd7:       s = 6'd38;
            4'd3, 4'd8:       s = 6'd37;
            4'd4:             s = 6'd35;
            4'd5:             s = 6'd40;
            4'd9:             s = 6'd36;
            4'd10:            s = 6'd33;
            default:          s = 6'd32;
        endcase
        return s;
    endfunction

    // ceil(2^shift / divisor): truncating division exact for dividends below 2^32
    function automatic logic [32:0] horner_recip(input logic [3:0] idx);
        logic [32:0] r;
        unique case (idx)
            4'd0:    r = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
            4'd1:    r = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
            4'd2:    r = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
            4'd3:    r = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
            4'd4:    r = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
            4'd5:    r = 33'(((64'd1 << 40) + 64'd131) / 64'd132);
            4'd6:    r = 33'(((64'd1 << 39) + 64'd89) / 64'd90);
            4'd7:    r = 33'(((64'd1 << 38) + 64'd55) / 64'd56);
            4'd8:    r = 33'(((64'd1 << 37) + 64'd29) / 64'd30);
            4'd9:    r = 33'(((64'd1 << 36) + 64'd11) / 64'd12);
            4'd10:   r = 33'((64'd1 << 33) / 64'd2);
            default: r = 33'(64'd1 << 32);
        endcase
        return r;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi) return hi[STATE_BITS-1:0];
        if (v < lo) return lo[STATE_BITS-1:0];
        return v[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [38:0] v);
        logic signed [38:0] hi;
        logic signed [38:0] lo;
        hi = 39'sd8388607;
        lo = -39'sd8388608;
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== rtl/rbf_fifo.sv =====
// Two-entry request queue used between the front and back ends and at the output.
// No package dependencies.
module rbf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // store incoming request
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 2'd1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// ===== rtl/rbf_front.sv =====
// Front end: configuration registers and decoding of incoming requests.
// Depends on rbf_pkg.
module rbf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [17:0]                    i_cfg_data,
    input  logic                           i_opcode,
    input  logic signed [rbf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [16:0]                    i_cutoff_hz,
    output rbf_pkg::t_job                  o_job,
    output rbf_pkg::t_cfg                  o_cfg
);
    import rbf_pkg::*;

    logic [1:0]  r_mode;
    logic [12:0] r_q;
    logic [17:0] r_fs;
    logic [16:0] w_f;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LP;
            r_q    <= 13'd0;
            r_fs   <= FS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                CFG_Q:    r_q    <= i_cfg_data[12:0];
                CFG_FS:   r_fs   <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // clamp the Q and sample-rate settings; the mode passes through
    always_comb begin
        o_cfg.mode = r_mode;
        o_cfg.qq   = (r_q < Q_MIN) ? Q_MIN : r_q;
        if (r_fs < FS_MIN)      o_cfg.fs = FS_MIN;
        else if (r_fs > FS_MAX) o_cfg.fs = FS_MAX;
        else                    o_cfg.fs = r_fs;
    end

    // classify the request and scale the cutoff by twice the table depth
    assign w_f        = (i_cutoff_hz == 17'd0) ? 17'd1 : i_cutoff_hz;
    assign o_job.clear = i_opcode;
    assign o_job.x     = i_sample_in;
    assign o_job.fscl  = {w_f, {(TAN_LOG + 1){1'b0}}};

endmodule

// ===== rtl/rbf_div.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on rbf_pkg.
module rbf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [rbf_pkg::DVD_BITS-1:0]  i_dvd,
    input  logic [rbf_pkg::DVS_BITS-1:0]  i_dvs,
    output logic                          o_done,
    output logic [rbf_pkg::DVD_BITS-1:0]  o_quo
);
    import rbf_pkg::*;

    logic [DVS_BITS-1:0] r_rem;
    logic [DVD_BITS-1:0] r_quo;
    logic [DVS_BITS-1:0] r_dvs;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DVS_BITS:0]   w_sh;
    logic                w_ge;
    logic [DVS_BITS:0]   w_sub;

    assign w_sh   = {r_rem, r_quo[DVD_BITS-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_sub  = w_sh - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // datapath: shift in one dividend bit, subtract where it fits
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DVS_BITS-1:0] : w_sh[DVS_BITS-1:0];
            r_quo <= {r_quo[DVD_BITS-2:0], w_ge};
        end
    end

    // step count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/rbf_back.sv =====
// Back end: coefficient sequencer with one shared multiplier and divider, and the
// two-pole recursion with its delay state. Depends on rbf_pkg and rbf_div.
module rbf_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_job_valid,
    input  rbf_pkg::t_job                          i_job,
    output logic                                   o_job_pop,
    input  rbf_pkg::t_cfg                          i_cfg,
    input  logic                                   i_res_full,
    output logic                                   o_res_push,
    output logic signed [rbf_pkg::SAMPLE_BITS-1:0] o_res
);
    import rbf_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_KW   = 5'd1;
    localparam logic [4:0] S_TH1  = 5'd2;
    localparam logic [4:0] S_TH2  = 5'd3;
    localparam logic [4:0] S_Z1   = 5'd4;
    localparam logic [4:0] S_Z2   = 5'd5;
    localparam logic [4:0] S_HM   = 5'd6;
    localparam logic [4:0] S_HD   = 5'd7;
    localparam logic [4:0] S_HW   = 5'd8;
    localparam logic [4:0] S_SN1  = 5'd9;
    localparam logic [4:0] S_SN2  = 5'd10;
    localparam logic [4:0] S_ALW  = 5'd11;
    localparam logic [4:0] S_B1W  = 5'd12;
    localparam logic [4:0] S_B2W  = 5'd13;
    localparam logic [4:0] S_GLW  = 5'd14;
    localparam logic [4:0] S_GBW  = 5'd15;
    localparam logic [4:0] S_CM1  = 5'd16;
    localparam logic [4:0] S_CM2  = 5'd17;
    localparam logic [4:0] S_CM3  = 5'd18;
    localparam logic [4:0] S_YB   = 5'd19;
    localparam logic [4:0] S_YC   = 5'd20;
    localparam logic [4:0] S_YD   = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    logic [4:0]                    r_state;
    logic [4:0]                    r_ret;
    logic                          r_div_go;
    logic [DVD_BITS-1:0]           r_dvd;
    logic [DVS_BITS-1:0]           r_dvs;
    logic                          r_dneg;
    logic signed [67:0]            r_prod;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [10:0]                   r_m;
    logic                          r_neg;
    t_q30                          r_theta;
    t_q30                          r_z;
    t_q30                          r_t;
    t_q30                          r_sn;
    t_q30                          r_cs;
    logic [3:0]                    r_hidx;
    logic [31:0]                   r_alpha;
    logic [31:0]                   r_a0;
    t_q30                          r_b1;
    t_q30                          r_b2;
    t_q30                          r_glp;
    t_q30                          r_gbp;
    t_q30                          r_cc;
    logic signed [34:0]            r_cv;
    logic signed [69:0]            r_acc;
    logic signed [37:0]            r_cm;
    logic signed [38:0]            r_yacc;
    logic signed [STATE_BITS-1:0]  r_y0;
    logic signed [STATE_BITS-1:0]  r_d1;
    logic signed [STATE_BITS-1:0]  r_d2;

    logic                          w_div_done;
    logic [DVD_BITS-1:0]           w_div_quo;
    logic signed [35:0]            w_quo;
    logic signed [33:0]            w_ma;
    logic signed [33:0]            w_mb;
    logic [67:0]                   w_pmag;
    logic [37:0]                   w_psh;
    logic signed [38:0]            w_pq;
    logic [67:0]                   w_hsh;
    logic [31:0]                   w_hq;
    logic signed [35:0]            w_hqs;
    logic [9:0]                    w_k;
    logic [10:0]                   w_n;
    logic [43:0]                   w_thsum;
    t_q30                          w_tnew;
    logic [31:0]                   w_alpha;
    logic [31:0]                   w_a0;
    logic [30:0]                   w_csmag;
    logic [31:0]                   w_a2;
    logic [31:0]                   w_omc;
    logic signed [69:0]            w_cmsum;
    logic signed [34:0]            w_vlp;
    logic signed [34:0]            w_vbp;
    logic signed [38:0]            w_hp;

    rbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_dvd   (r_dvd),
        .i_dvs   (r_dvs),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // signed quotient, sign restored after the magnitude division
    assign w_quo = r_dneg ? -$signed({1'b0, w_div_quo[34:0]})
                          :  $signed({1'b0, w_div_quo[34:0]});

    // angle index, odd step count and fold into the first quadrant
    assign w_k = (w_div_quo > DVD_BITS'(TAN_DEPTH - 1)) ? 10'(TAN_DEPTH - 1) : w_div_quo[9:0];
    assign w_n = {w_k, 1'b1};

    // shared multiplier operand selection
    always_comb begin
        unique case (r_state)
            S_TH1:   begin w_ma = $signed({23'd0, r_m}); w_mb = PI_Q30;  end
            S_Z1:    begin w_ma = r_theta;                w_mb = r_theta; end
            S_HM:    begin w_ma = r_z;                    w_mb = r_t;     end
            S_HD: begin
                w_ma = $signed({2'b00, w_psh[31:0]});
                w_mb = $signed({1'b0, horner_recip(r_hidx)});
            end
            S_SN1:   begin w_ma = r_theta;                w_mb = r_t;     end
            S_CM1:   begin w_ma = r_cc; w_mb = $signed({{16{r_cv[34]}}, r_cv[34:17]}); end
            S_CM2:   begin w_ma = r_cc; w_mb = $signed({17'd0, r_cv[16:0]});           end
            default: begin w_ma = '0;                     w_mb = '0;      end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Q30 product truncated toward zero
    assign w_pmag = r_prod[67] ? 68'(-r_prod) : 68'(r_prod);
    assign w_psh  = w_pmag[67:30];
    assign w_pq   = r_prod[67] ? -$signed({1'b0, w_psh}) : $signed({1'b0, w_psh});

    // Taylor term division by reciprocal multiplication, sign restored afterwards
    assign w_hsh = w_pmag >> horner_shift(r_hidx);
    assign w_hq  = w_hsh[31:0];
    assign w_hqs = r_dneg ? -$signed({4'd0, w_hq}) : $signed({4'd0, w_hq});

    assign w_thsum = r_prod[43:0] + 44'(TAN_DEPTH);
    assign w_tnew  = t_q30'(36'(Q_ONE) - w_hqs);
    assign w_alpha = w_div_quo[31:0];
    assign w_a0    = 32'(Q_ONE) + w_alpha;
    assign w_csmag = r_cs[33] ? 31'(-r_cs) : r_cs[30:0];
    assign w_a2    = 32'(Q_ONE) - r_alpha;
    assign w_omc   = 32'(Q_ONE - r_cs);

    assign w_cmsum = r_acc + 70'(r_prod);
    assign w_vlp   = 35'(r_y0) + (35'(r_d1) <<< 1) + 35'(r_d2);
    assign w_vbp   = 35'(r_y0) - 35'(r_d2);
    assign w_hp    = 39'(r_x) - 39'(r_cm);

    // result by mode
    always_comb begin
        unique case (i_cfg.mode)
            MODE_LP: o_res = sat_sample(39'(r_cm));
            MODE_HP: o_res = sat_sample(w_hp);
            MODE_BP: o_res = sat_sample(39'(r_cm));
            default: o_res = '0;
        endcase
    end

    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x    <= i_job.x;
                r_dvd  <= DVD_BITS'(i_job.fscl);
                r_dvs  <= DVS_BITS'(i_cfg.fs);
                r_dneg <= 1'b0;
            end
            S_KW: begin
                r_neg <= (w_n > 11'(TAN_DEPTH));
                r_m   <= (w_n > 11'(TAN_DEPTH)) ? 11'(2 * TAN_DEPTH) - w_n : w_n;
            end
            S_TH2: r_theta <= $signed({1'b0, w_thsum[43:TAN_LOG + 1]});
            S_Z2: begin
                r_z    <= $signed({1'b0, r_prod[62:30]});
                r_t    <= Q_ONE;
                r_hidx <= 4'd0;
            end
            S_HD: r_dneg <= r_prod[67];
            S_HW: begin
                r_t    <= w_tnew;
                r_hidx <= r_hidx + 4'd1;
                r_cs   <= r_neg ? -w_tnew : w_tnew;
                r_dvd  <= {21'd0, r_sn, 7'd0};
                r_dvs  <= DVS_BITS'(i_cfg.qq);
                r_dneg <= 1'b0;
            end
            S_SN2: begin
                r_sn <= w_pq[33:0];
                r_t  <= Q_ONE;
            end
            S_ALW: begin
                if (w_div_done) begin
                    r_alpha <= w_alpha;
                    r_a0    <= w_a0;
                    r_dvd   <= {w_csmag, 1'b0, 30'd0};
                    r_dvs   <= w_a0;
                    r_dneg  <= (r_cs > 0);
                end
            end
            S_B1W: begin
                if (w_div_done) begin
                    r_b1   <= w_quo[33:0];
                    r_dvd  <= {w_a2, 30'd0};
                    r_dneg <= 1'b0;
                end
            end
            S_B2W: begin
                if (w_div_done) begin
                    r_b2  <= w_quo[33:0];
                    r_dvd <= {w_omc, 30'd0};
                    r_dvs <= {r_a0[30:0], 1'b0};
                end
            end
            S_GLW: begin
                if (w_div_done) begin
                    r_glp <= w_quo[33:0];
                    r_dvd <= {r_sn[31:0], 30'd0};
                end
            end
            S_GBW: begin
                if (w_div_done) begin
                    r_gbp <= w_quo[33:0];
                    r_cc  <= r_b2;
                    r_cv  <= 35'(r_d2);
                end
            end
            S_CM2: r_acc <= $signed({r_prod[52:0], 17'd0});
            S_CM3: r_cm  <= w_cmsum[67:30];
            S_YB: begin
                r_yacc <= 39'(r_x) - 39'(r_cm);
                r_cc   <= r_b1;
                r_cv   <= 35'(r_d1);
            end
            S_YC: r_y0 <= sat_state(40'(r_yacc) - 40'(r_cm));
            S_YD: begin
                r_cc <= (i_cfg.mode == MODE_BP) ? r_gbp : r_glp;
                r_cv <= (i_cfg.mode == MODE_BP) ? w_vbp : w_vlp;
                if (i_cfg.mode != MODE_LP && i_cfg.mode != MODE_HP &&
                    i_cfg.mode != MODE_BP) begin
                    r_cm <= '0;
                end
            end
            default: ;
        endcase
    end

    // sequencer and delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_div_go <= 1'b0;
            r_d1     <= '0;
            r_d2     <= '0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.clear) begin
                            r_d1 <= '0;
                            r_d2 <= '0;
                        end else begin
                            r_div_go <= 1'b1;
                            r_state  <= S_KW;
                        end
                    end
                end
                S_KW:  if (w_div_done) r_state <= S_TH1;
                S_TH1: r_state <= S_TH2;
                S_TH2: r_state <= S_Z1;
                S_Z1:  r_state <= S_Z2;
                S_Z2:  r_state <= S_HM;
                S_HM:  r_state <= S_HD;
                S_HD:  r_state <= S_HW;
                S_HW: begin
                    priority if (r_hidx == 4'd4) begin
                        r_state <= S_SN1;
                    end else if (r_hidx == 4'd10) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_ALW;
                    end else begin
                        r_state <= S_HM;
                    end
                end
                S_SN1: r_state <= S_SN2;
                S_SN2: r_state <= S_HM;
                S_ALW: if (w_div_done) begin r_div_go <= 1'b1; r_state <= S_B1W; end
                S_B1W: if (w_div_done) begin r_div_go <= 1'b1; r_state <= S_B2W; end
                S_B2W: if (w_div_done) begin r_div_go <= 1'b1; r_state <= S_GLW; end
                S_GLW: if (w_div_done) begin r_div_go <= 1'b1; r_state <= S_GBW; end
                S_GBW: begin
                    if (w_div_done) begin
                        r_ret   <= S_YB;
                        r_state <= S_CM1;
                    end
                end
                S_CM1: r_state <= S_CM2;
                S_CM2: r_state <= S_CM3;
                S_CM3: r_state <= r_ret;
                S_YB: begin
                    r_ret   <= S_YC;
                    r_state <= S_CM1;
                end
                S_YC: r_state <= S_YD;
                S_YD: begin
                    r_ret <= S_OUT;
                    if (i_cfg.mode == MODE_LP || i_cfg.mode == MODE_HP ||
                        i_cfg.mode == MODE_BP) begin
                        r_state <= S_CM1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_d2    <= r_d1;
                        r_d1    <= r_y0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/resonant_biquad_filter.sv =====
// Resonant biquad filter, top level: front end, request queue, back end, result queue.
// A filter request makes six passes of the shared divider (angle index, alpha, four
// coefficients), plus sequencing, Taylor terms by reciprocal multiply and coefficient
// products (the output product skipped in the unused mode); a clear request only
// zeroes the delays. The back end takes one request at a time; the request queue holds two
// more. Reset is synchronous and active low: queues empty, delays zero, defaults.
module resonant_biquad_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   i_opcode,
    input  logic signed [rbf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [16:0]                            i_cutoff_hz,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [17:0]                            i_cfg_data,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [rbf_pkg::SAMPLE_BITS-1:0] o_sample_out
);
    import rbf_pkg::*;

    t_job                    w_job_in;
    t_job                    w_job_out;
    t_cfg                    w_cfg;
    logic                    w_job_empty;
    logic                    w_job_pop;
    logic                    w_res_full;
    logic                    w_res_push;
    logic [SAMPLE_BITS-1:0]  w_res;
    logic [SAMPLE_BITS-1:0]  w_res_q;

    rbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_opcode    (i_opcode),
        .i_sample_in (i_sample_in),
        .i_cutoff_hz (i_cutoff_hz),
        .o_job       (w_job_in),
        .o_cfg       (w_cfg)
    );

    rbf_fifo #(.WIDTH($bits(t_job))) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_data  (w_job_out)
    );

    rbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_cfg       (w_cfg),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    rbf_fifo #(.WIDTH(SAMPLE_BITS)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_q)
    );

    assign o_sample_out = $signed(w_res_q);

endmodule

// ===== tb/resonant_biquad_filter_tb.sv =====
// Self-checking testbench for resonant_biquad_filter: a clocked driver, a monitor and
// a bit-exact predictor of the fixed-point biquad. Depends on rbf_pkg and the RTL top.
module resonant_biquad_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbf_pkg::*;

    localparam longint QONE       = longint'(1) << 30;
    localparam longint PI_FIX     = 64'sd3373259426;
    localparam int     SETTLE     = 1300;
    localparam int     STALL_MAX  = 20000;

    typedef struct {
        bit          op;
        logic [23:0] smp;
        logic [16:0] fc;
    } req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_opcode = 1'b0;
    logic [23:0] i_sample_in = '0;
    logic [16:0] i_cutoff_hz = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MODE;
    logic [17:0] i_cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [23:0] o_sample_out;

    req_t        pending_reqs[$];
    logic [23:0] expected_samples[$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          holding = 0;
    bit          quiet = 0;
    int          push_idle = 0;
    int          pop_idle = 0;

    // predictor state and configuration
    logic [1:0]  mode_m = MODE_LP;
    logic [12:0] q_m = '0;
    logic [17:0] fs_m = FS_RESET;
    longint      dly_one = 0;
    longint      dly_two = 0;

    resonant_biquad_filter i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_sample_in  (i_sample_in),
        .i_cutoff_hz  (i_cutoff_hz),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint floor_quot(longint v, longint n);
        if (v >= 0) return v / n;
        return -((-v + n - 1) / n);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        return (a * b) / QONE;
    endfunction

    // exact floor(c*y / 2^30), split so the products stay in 64 bits
    function automatic longint coef_scale(longint c, longint y);
        longint yl, yh, p, ph, pl, q;
        yl = longint'(y & 64'hFFFFF);
        yh = (y - yl) / (longint'(1) << 20);
        p  = c * yh;
        ph = floor_quot(p, 1024);
        pl = p - ph * 1024;
        q  = c * yl;
        return ph + floor_quot(pl * (longint'(1) << 20) + q, QONE);
    endfunction

    function automatic longint clip_bits(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint taylor_poly(longint z, bit cosine);
        longint sdiv[5] = '{110, 72, 42, 20, 6};
        longint cdiv[6] = '{132, 90, 56, 30, 12, 2};
        longint t;
        t = QONE;
        for (int i = 0; i < (cosine ? 6 : 5); i++)
            t = QONE - fix_mul(z, t) / (cosine ? cdiv[i] : sdiv[i]);
        return t;
    endfunction

    // advance the predicted delay line by one sample and return the output
    function automatic logic [23:0] filter_sample(logic [23:0] xin, logic [16:0] fc);
        longint x, fs, f, k, n, m, theta, z, sn, cs, qq, alpha, a0, a1, a2;
        longint b1, b2, glp, gbp, y0, lp, res;
        bit neg;
        x  = longint'($signed(xin));
        fs = fs_m;
        if (fs < 1000) fs = 1000;
        if (fs > 192000) fs = 192000;
        f = fc;
        if (f < 1) f = 1;
        k = (2 * f * TAN_DEPTH) / fs;
        if (k > TAN_DEPTH - 1) k = TAN_DEPTH - 1;
        n = 2 * k + 1;
        neg = n > TAN_DEPTH;
        m = neg ? 2 * TAN_DEPTH - n : n;
        theta = (m * PI_FIX + TAN_DEPTH) / (2 * TAN_DEPTH);
        z  = fix_mul(theta, theta);
        sn = fix_mul(theta, taylor_poly(z, 0));
        cs = taylor_poly(z, 1);
        if (neg) cs = -cs;
        qq = q_m;
        if (qq < 256) qq = 256;
        alpha = (sn * 128) / qq;
        a0  = QONE + alpha;
        a1  = -2 * cs;
        a2  = QONE - alpha;
        b1  = (a1 * QONE) / a0;
        b2  = (a2 * QONE) / a0;
        glp = ((QONE - cs) * QONE) / (2 * a0);
        gbp = (sn * QONE) / (2 * a0);
        y0 = clip_bits(x - coef_scale(b2, dly_two) - coef_scale(b1, dly_one), STATE_BITS);
        lp = coef_scale(glp, y0 + 2 * dly_one + dly_two);
        case (mode_m)
            MODE_LP: res = lp;
            MODE_HP: res = x - lp;
            MODE_BP: res = coef_scale(gbp, y0 - dly_two);
            default: res = 0;
        endcase
        dly_two = dly_one;
        dly_one = y0;
        res = clip_bits(res, SAMPLE_BITS);
        return res[23:0];
    endfunction

    task automatic report_mismatch(logic [23:0] got, logic [23:0] want);
        $display("mismatch on sample_out: got %0d expected %0d",
                 $signed(got), $signed(want));
        mismatches++;
    endtask

    // drive requests at the falling edge, with random gaps before some of them unless quiet
    always @(negedge i_clk) begin
        if (i_rst_n && !holding) begin
            if (push_idle > 0) begin
                push_idle--;
                push = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                push_idle = $urandom_range(1, 17) - 1;
                push = 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_t r;
                r = pending_reqs.pop_front();
                i_opcode = r.op;
                i_sample_in = r.smp;
                i_cutoff_hz = r.fc;
                push = 1'b1;
                holding = 1;
            end else begin
                push = 1'b0;
            end
        end
    end

    // drive pop at the falling edge, stalling in bursts
    always @(negedge i_clk) begin
        if (pop_idle > 0) begin
            pop_idle--;
            pop = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop_idle = $urandom_range(1, 17) - 1;
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    // sample both handshakes at the rising edge; predict and check
    always @(posedge i_clk) begin
        bit moved;
        moved = 0;
        if (i_rst_n && push && !full) begin
            moved = 1;
            holding = 0;
            if (i_opcode) begin
                dly_one = 0;
                dly_two = 0;
            end else begin
                expected_samples.push_back(filter_sample(i_sample_in, i_cutoff_hz));
            end
        end
        if (i_rst_n && pop && !empty) begin
            moved = 1;
            if (expected_samples.size() == 0) begin
                $display("unexpected result: sample_out %0d", $signed(o_sample_out));
                mismatches++;
            end else begin
                logic [23:0] want;
                want = expected_samples.pop_front();
                if (o_sample_out !== want) report_mismatch(o_sample_out, want);
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_req(bit op, logic [23:0] smp, logic [16:0] fc);
        req_t r;
        r.op = op;
        r.smp = smp;
        r.fc = fc;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(int count);
        logic [16:0] fc;
        logic [23:0] smp;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) fc = $urandom_range(20, 20000);
            else if (sel < 9) fc = $urandom_range(0, 96000);
            else fc = $urandom;
            sel = $urandom_range(0, 19);
            if (sel == 0) smp = 24'h7FFFFF;
            else if (sel == 1) smp = 24'h800000;
            else smp = $urandom;
            queue_req($urandom_range(0, 12) == 0, smp, fc);
        end
    endtask

    // hold until everything has drained, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || holding || expected_samples.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [17:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE: mode_m = data[1:0];
            CFG_Q:    q_m = data[12:0];
            default:  fs_m = data;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [1:0]  modes[7] = '{MODE_HP, MODE_BP, 2'd3, MODE_LP, MODE_HP, MODE_BP, MODE_LP};
        int          qs[7]    = '{8191, 256, 300, 4000, 255, 1024, 700};
        int          rates[7] = '{1000, 192000, 44100, 0, 262143, 96000, 8000};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes under the reset settings
        queue_req(0, 24'h7FFFFF, 17'd1000);
        queue_req(0, 24'h7FFFFF, 17'd1000);
        queue_req(0, 24'h800000, 17'd0);
        queue_req(0, 24'h000000, 17'd1);
        queue_req(0, 24'h7FFFFF, 17'd96000);
        queue_req(0, 24'h800000, 17'd131071);
        queue_req(0, 24'h800000, 17'd24000);
        queue_req(1, 24'hFFFFFF, 17'h1FFFF);
        queue_req(0, 24'h000001, 17'd23999);
        queue_req(0, 24'hFFFFFF, 17'd12000);
        queue_req(0, 24'h7FFFFF, 17'd5);
        queue_req(0, 24'h7FFFFF, 17'd5);
        queue_req(1, 24'h000000, 17'd0);
        queue_req(0, 24'h555555, 17'h0AAAA);
        queue_req(0, 24'hAAAAAA, 17'h15555);
        queue_random(240);
        drain();

        // sweep the settings, extremes and out-of-range values among them
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_MODE, 18'(modes[p]));
            write_reg(CFG_Q, 18'(qs[p]));
            write_reg(CFG_FS, 18'(rates[p]));
            if (p == 6) quiet = 1;
            queue_req(0, 24'h7FFFFF, 17'd1);
            queue_req(0, 24'h800000, 17'd131071);
            queue_random(240);
            drain();
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
